// ===== src/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/bump_pkg.sv =====
`timescale 1ns / 1ps
package bump_pkg;

  localparam int ADDR_BITS_DEF = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_LOG2    = 2'd3;

  localparam logic [31:0] RESERVED_RESET = 32'h4000_0000;
  localparam logic [4:0]  PAGE_LOG2_RESET = 5'd12;
  localparam logic [4:0]  COMMIT_LOG2_RESET = 5'd12;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_REALLOC = 3'd1;
  localparam logic [2:0] OP_MARKER  = 3'd2;
  localparam logic [2:0] OP_PURGE   = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NULL     = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_NOT_OWN  = 3'd3;
  localparam logic [2:0] ST_MARK_TOP = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] alloc_size;
    logic [4:0]  align_log2;
    logic [31:0] address;
    logic        ptr_valid;
    logic [31:0] prev_size;
    logic [31:0] marker;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [31:0] copy_bytes;
    logic        owned;
    logic [31:0] alloc_top;
    logic [31:0] commit_top;
  } out_item_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [31:0] reserved_bytes;
    logic [4:0]  page_log2;
    logic [4:0]  commit_block_log2;
  } cfg_t;

  // request after the input register, with terms from the item and the config worked out
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] size;
    logic [31:0] align_mask;
    logic [31:0] addr;
    logic        ptr_valid;
    logic [31:0] marker;
    logic        size_zero;
    logic        size_over;
    logic [31:0] room;
    logic [31:0] copy_len;
  } prep_t;

  function automatic logic [31:0] low_mask(input logic [4:0] lg);
    logic [32:0] one_hot;
    one_hot = 33'd1 << lg;
    return 32'(one_hot - 33'd1);
  endfunction

endpackage

// ===== src/bump_in_stage.sv =====
`timescale 1ns / 1ps
module bump_in_stage #(
  parameter int ADDR_BITS = bump_pkg::ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bump_pkg::in_item_t in_data,
  input  bump_pkg::cfg_t    cfg,
  input  logic              exec_ready,
  output logic              req_valid,
  output bump_pkg::prep_t   req
);

  localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                : 32'((64'd1 << ADDR_BITS) - 64'd1);

  logic            accept;
  logic            take;
  bump_pkg::prep_t prep;

  assign take     = req_valid && exec_ready;
  assign in_stall = req_valid && !exec_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    prep.opcode     = in_data.opcode;
    prep.size       = in_data.alloc_size;
    prep.align_mask = bump_pkg::low_mask(in_data.align_log2);
    prep.addr       = in_data.address & AMASK;
    prep.ptr_valid  = in_data.ptr_valid;
    prep.marker     = in_data.marker;
    prep.size_zero  = (in_data.alloc_size == 32'd0);
    prep.size_over  = (in_data.alloc_size > cfg.reserved_bytes);
    prep.room       = cfg.reserved_bytes - in_data.alloc_size;
    prep.copy_len   = (in_data.prev_size < in_data.alloc_size) ? in_data.prev_size
                                                               : in_data.alloc_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (take) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= prep;
    end
  end

endmodule

// ===== src/bump_exec.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bump_exec #(
  parameter int ADDR_BITS = bump_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  bump_pkg::prep_t    req,
  input  bump_pkg::cfg_t     cfg,
  output logic               exec_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output bump_pkg::out_item_t out_data
);

  // past 34 bits no sum here can wrap, so wider address spaces behave alike
  localparam int IW = (ADDR_BITS < 34) ? ADDR_BITS : 34;

  logic [31:0] bump_top;
  logic [31:0] commit_mark;
  logic [31:0] last_offset;
  logic        has_last;
  logic [31:0] bump_top_next;
  logic [31:0] commit_mark_next;
  logic [31:0] last_offset_next;
  logic        has_last_next;

  logic                take;
  bump_pkg::out_item_t res;

  logic [33:0]   base34;
  logic [IW-1:0] cur;
  logic [IW-1:0] amask;
  logic [IW-1:0] aligned;
  logic [IW-1:0] off;
  logic [33:0]   off34;
  logic          bump_fail;
  logic [31:0]   top_bump;
  logic          own;
  logic [IW-1:0] last_abs;
  logic          is_last;
  logic          ip_fail;
  logic [31:0]   top_ip;
  logic [4:0]    commit_lg;
  logic [32:0]   cmask;
  logic [32:0]   pmask;
  logic [31:0]   commit_tgt;
  logic [32:0]   commit_rnd;
  logic [31:0]   commit_cap;
  logic [32:0]   keep;

  assign take       = req_valid && exec_ready;
  assign exec_ready = !out_valid || !out_stall;

  always_comb begin
    base34    = {2'b00, cfg.base_address};
    cur       = IW'(base34 + {2'b00, bump_top});
    amask     = IW'({2'b00, req.align_mask});
    aligned   = (cur + amask) & ~amask;
    off       = aligned - IW'(base34);
    off34     = 34'(off);
    bump_fail = (off34 < {2'b00, bump_top}) || req.size_over
             || (off34 > {2'b00, req.room});
    top_bump  = off34[31:0] + req.size;

    own      = (req.addr >= cfg.base_address)
            && ((req.addr - cfg.base_address) < bump_top);
    last_abs = IW'(base34 + {2'b00, last_offset});
    is_last  = has_last && (34'(req.addr) == 34'(last_abs));
    ip_fail  = req.size_over || (last_offset > req.room);
    top_ip   = last_offset + req.size;

    commit_lg  = (cfg.commit_block_log2 < cfg.page_log2) ? cfg.page_log2
                                                         : cfg.commit_block_log2;
    cmask      = {1'b0, bump_pkg::low_mask(commit_lg)};
    pmask      = {1'b0, bump_pkg::low_mask(cfg.page_log2)};
    commit_tgt = is_last && req.opcode == bump_pkg::OP_REALLOC && req.ptr_valid
               ? top_ip : top_bump;
    commit_rnd = ({1'b0, commit_tgt} + cmask) & ~cmask;
    commit_cap = (commit_rnd > {1'b0, cfg.reserved_bytes}) ? cfg.reserved_bytes
                                                           : commit_rnd[31:0];
    keep       = ({1'b0, bump_top} + pmask) & ~pmask;
  end

  always_comb begin
    logic do_bump;
    logic do_move;
    logic do_inplace;
    do_bump          = 1'b0;
    do_move          = 1'b0;
    do_inplace       = 1'b0;
    bump_top_next    = bump_top;
    commit_mark_next = commit_mark;
    last_offset_next = last_offset;
    has_last_next    = has_last;
    res.status         = bump_pkg::ST_OK;
    res.result_address = 32'd0;
    res.copy_bytes     = 32'd0;
    res.owned          = 1'b0;

    case (req.opcode)
      bump_pkg::OP_ALLOC: begin
        do_bump = 1'b1;
      end
      bump_pkg::OP_REALLOC: begin
        if (!req.ptr_valid) begin
          do_bump = 1'b1;
        end else if (req.size_zero) begin
          res.status = bump_pkg::ST_NULL;
        end else if (!own) begin
          res.status = bump_pkg::ST_NOT_OWN;
        end else if (is_last) begin
          do_inplace = 1'b1;
        end else begin
          do_bump = 1'b1;
          do_move = 1'b1;
        end
      end
      bump_pkg::OP_MARKER: begin
        if (req.marker > bump_top) begin
          res.status = bump_pkg::ST_MARK_TOP;
        end else begin
          bump_top_next = req.marker;
          has_last_next = 1'b0;
        end
      end
      bump_pkg::OP_PURGE: begin
        if (keep < {1'b0, commit_mark}) begin
          commit_mark_next = keep[31:0];
        end
      end
      bump_pkg::OP_QUERY: begin
        res.owned = own;
      end
      default: begin
      end
    endcase

    if (do_bump) begin
      if (req.size_zero) begin
        res.status = bump_pkg::ST_NULL;
      end else if (bump_fail) begin
        res.status = bump_pkg::ST_NO_SPACE;
      end else begin
        bump_top_next      = top_bump;
        last_offset_next   = off34[31:0];
        has_last_next      = 1'b1;
        res.result_address = 32'(aligned);
        if (top_bump > commit_mark) begin
          commit_mark_next = commit_cap;
        end
        if (do_move) begin
          res.copy_bytes = req.copy_len;
        end
      end
    end

    if (do_inplace) begin
      if (ip_fail) begin
        res.status = bump_pkg::ST_NO_SPACE;
      end else begin
        bump_top_next      = top_ip;
        res.result_address = req.addr;
        if (top_ip > bump_top && top_ip > commit_mark) begin
          commit_mark_next = commit_cap;
        end
      end
    end

    res.alloc_top  = bump_top_next;
    res.commit_top = commit_mark_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_top    <= 32'd0;
      commit_mark <= 32'd0;
      last_offset <= 32'd0;
      has_last    <= 1'b0;
    end else if (take) begin
      bump_top    <= bump_top_next;
      commit_mark <= commit_mark_next;
      last_offset <= last_offset_next;
      has_last    <= has_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_stall == 1'b0) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

  `ASSERT_IMPLIES(a_state_needs_take, !$past(take) && !$past(rst),
                  $stable(bump_top) && $stable(commit_mark))
  `ASSERT_IMPLIES(a_last_below_top, has_last, last_offset < bump_top)
  `ASSERT_IMPLIES(a_fail_no_addr, out_valid && out_data.status != bump_pkg::ST_OK,
                  out_data.result_address == 32'd0)
  `ASSERT_IMPLIES(a_copy_only_ok, out_valid && out_data.copy_bytes != 32'd0,
                  out_data.status == bump_pkg::ST_OK)

endmodule

// ===== src/bump_arena_allocator_core.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// in       in   in_valid / in_stall   in_data   (bump_pkg::in_item_t)
// out      out  out_valid / out_stall out_data  (bump_pkg::out_item_t)
// cfg      in   cfg_we                cfg_index, cfg_wdata
//
// one beat in, one beat out; a request is held in the input register, then
// in the output register; a new request can be taken every cycle while
// out_stall is low; the single execute stage reads and updates the arena state
// rst clears state and config to their defaults
// a stalled result stays in the output register while one more request waits
// in the input register
module bump_arena_allocator_core #(
  parameter int ADDR_BITS = bump_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bump_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bump_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [bump_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bump_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  bump_pkg::cfg_t  cfg;
  logic            req_valid;
  bump_pkg::prep_t req;
  logic            exec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address      <= 32'd0;
      cfg.reserved_bytes    <= bump_pkg::RESERVED_RESET;
      cfg.page_log2         <= bump_pkg::PAGE_LOG2_RESET;
      cfg.commit_block_log2 <= bump_pkg::COMMIT_LOG2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bump_pkg::CFG_BASE_ADDRESS:   cfg.base_address      <= cfg_wdata;
        bump_pkg::CFG_RESERVED_BYTES: cfg.reserved_bytes    <= cfg_wdata;
        bump_pkg::CFG_PAGE_LOG2:      cfg.page_log2         <= cfg_wdata[4:0];
        bump_pkg::CFG_COMMIT_LOG2:    cfg.commit_block_log2 <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  bump_in_stage #(
    .ADDR_BITS (ADDR_BITS)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg),
    .exec_ready (exec_ready),
    .req_valid  (req_valid),
    .req        (req)
  );

  bump_exec #(
    .ADDR_BITS (ADDR_BITS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .cfg        (cfg),
    .exec_ready (exec_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
